FILE: rtl/kmpss_pkg.sv
// Shared constants and types for the KMP substring search unit.
package kmpss_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_TEXT_DEF    = 65536;

  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int IDX_W     = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;

  localparam logic signed [IDX_W-1:0] NOT_FOUND = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic clear;
    logic advance;
  } cell_ctrl_t;

endpackage

FILE: rtl/kmpss_cell.sv
// One match cell: compares its pattern byte and tracks a prefix match ending here.
module kmpss_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kmpss_pkg::cell_ctrl_t           ctrl,
  input  logic [kmpss_pkg::BYTE_W-1:0]    pat_byte,
  input  logic [kmpss_pkg::BYTE_W-1:0]    text_byte,
  input  logic                            prev_match,
  output logic                            cmp_hit,
  output logic                            match_r
);

  logic match_nxt;

  assign cmp_hit = prev_match && (text_byte == pat_byte);

  always_comb begin
    priority if (ctrl.clear) begin
      match_nxt = 1'b0;
    end else if (ctrl.advance) begin
      match_nxt = cmp_hit;
    end else begin
      match_nxt = match_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

endmodule

FILE: rtl/kmp_substring_search_unit.sv
// Top level of the KMP substring search unit: cell chain, text counter and result register.
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   input   | in_valid, in_stall, in_text_byte, in_text_last     | in
//   result  | out_valid, out_stall, out_found, out_match_index,  | out
//           | out_too_long                                       |
//   config  | cfg_we, cfg_index, cfg_data                        | in
//
// One text byte is taken per cycle while in_stall is low; every cell compares it in the same cycle.
// The result for a byte is registered and shows in the cycle after that byte is taken.
// Reset clears pattern, cell matches, text counter and out_valid, but not the result data.
// in_stall is high only while a result waits with out_stall high.
module kmp_substring_search_unit #(
  parameter int MAX_PATTERN = kmpss_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = kmpss_pkg::MAX_TEXT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [kmpss_pkg::BYTE_W-1:0]          in_text_byte,
  input  logic                                  in_text_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_found,
  output logic signed [kmpss_pkg::IDX_W-1:0]    out_match_index,
  output logic                                  out_too_long,
  input  logic                                  cfg_we,
  input  logic [kmpss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kmpss_pkg::CFG_W-1:0]           cfg_data
);

  localparam int OFF_W = $clog2(MAX_TEXT + 1);
  localparam int SUM_W = (OFF_W > kmpss_pkg::IDX_W) ? OFF_W : kmpss_pkg::IDX_W;

  logic [kmpss_pkg::PAT_W-1:0]  pat_r, pat_nxt;
  logic [kmpss_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [OFF_W-1:0]             off_r, off_nxt;
  logic                         rep_r, rep_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic signed [kmpss_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                         out_too_long_r, out_too_long_nxt;

  logic                         acc;
  logic                         too_far;
  logic [kmpss_pkg::LEN_W-1:0]  n;
  logic                         hit;
  logic                         emit;
  logic [SUM_W-1:0]             off_ext;
  logic [SUM_W-1:0]             start_idx;
  kmpss_pkg::cell_ctrl_t        ctrl;
  logic [MAX_PATTERN-1:0]       cmp_hit;
  logic [MAX_PATTERN-1:0]       match_r;
  logic [MAX_PATTERN-1:0]       prev_match;

  assign acc      = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign too_far  = off_r >= OFF_W'(MAX_TEXT);
  assign n        = (len_r > kmpss_pkg::LEN_W'(MAX_PATTERN)) ?
                    kmpss_pkg::LEN_W'(MAX_PATTERN) : len_r;
  assign off_ext   = SUM_W'(off_r);
  assign start_idx = off_ext + SUM_W'(1) - SUM_W'(n);

  assign ctrl.clear   = cfg_we || (acc && in_text_last);
  assign ctrl.advance = acc && !rep_r && !too_far && (n != '0);

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign prev_match[g] = 1'b1;
      end else begin : g_link
        assign prev_match[g] = match_r[g-1];
      end
      kmpss_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pat_byte   (pat_r[g*kmpss_pkg::BYTE_W +: kmpss_pkg::BYTE_W]),
        .text_byte  (in_text_byte),
        .prev_match (prev_match[g]),
        .cmp_hit    (cmp_hit[g]),
        .match_r    (match_r[g])
      );
    end
  endgenerate

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (cmp_hit[i] && (n == kmpss_pkg::LEN_W'(i + 1))) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    pat_nxt = pat_r;
    len_nxt = len_r;
    if (cfg_we) begin
      unique case (kmpss_pkg::cfg_reg_t'(cfg_index))
        kmpss_pkg::CFG_PATTERN_BYTES:  pat_nxt = cfg_data;
        kmpss_pkg::CFG_PATTERN_LENGTH: len_nxt = cfg_data[kmpss_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    emit             = 1'b0;
    out_found_nxt    = out_found_r;
    out_idx_nxt      = out_idx_r;
    out_too_long_nxt = out_too_long_r;
    rep_nxt          = rep_r;
    off_nxt          = off_r;
    if (acc && !rep_r) begin
      priority if (too_far) begin
        emit             = 1'b1;
        out_found_nxt    = 1'b0;
        out_idx_nxt      = kmpss_pkg::NOT_FOUND;
        out_too_long_nxt = 1'b1;
      end else if (n == '0) begin
        emit             = 1'b1;
        out_found_nxt    = 1'b1;
        out_idx_nxt      = off_ext[kmpss_pkg::IDX_W-1:0];
        out_too_long_nxt = 1'b0;
      end else begin
        off_nxt = off_r + OFF_W'(1);
        if (hit) begin
          emit             = 1'b1;
          out_found_nxt    = 1'b1;
          out_idx_nxt      = start_idx[kmpss_pkg::IDX_W-1:0];
          out_too_long_nxt = 1'b0;
        end
      end
      if (emit) begin
        rep_nxt = 1'b1;
      end else if (in_text_last) begin
        emit             = 1'b1;
        out_found_nxt    = 1'b0;
        out_idx_nxt      = kmpss_pkg::NOT_FOUND;
        out_too_long_nxt = 1'b0;
      end
    end
    if (acc && in_text_last) begin
      rep_nxt = 1'b0;
      off_nxt = '0;
    end
  end

  always_comb begin
    priority if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= '0;
      len_r       <= '0;
      off_r       <= '0;
      rep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_r       <= pat_nxt;
      len_r       <= len_nxt;
      off_r       <= off_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r    <= out_found_nxt;
    out_idx_r      <= out_idx_nxt;
    out_too_long_r <= out_too_long_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_idx_r;
  assign out_too_long    = out_too_long_r;

endmodule

FILE: rtl/kmpss_checker.sv
// Port-level checks for the KMP substring search unit, bound to the top level.
module kmpss_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 out_found,
  input logic signed [kmpss_pkg::IDX_W-1:0]   out_match_index,
  input logic                                 out_too_long
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
      $stable(out_match_index) && $stable(out_too_long))
    else $error("result changed while stalled");

  a_found_not_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_too_long)
    else $error("found and too_long both set");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_index == kmpss_pkg::NOT_FOUND)
    else $error("miss without not-found index");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_new_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted item");

endmodule

bind kmp_substring_search_unit kmpss_checker u_kmpss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found       (out_found),
  .out_match_index (out_match_index),
  .out_too_long    (out_too_long)
);
